@@ src/gcib_pkg.sv @@
// Shared constants, widths and the arctangent step table for the bearing pipeline.
`default_nettype none
package gcib_pkg;
  localparam int ANGLE_BITS = 32;
  localparam int ITERS      = 24;
  localparam int UPSH       = (ANGLE_BITS >= 32) ? ANGLE_BITS - 32 : 0;
  localparam int DNSH       = (ANGLE_BITS < 32) ? 32 - ANGLE_BITS : 0;
  localparam int QSHIFT     = 30;
  localparam int ZW         = ANGLE_BITS + 2;
  localparam int SW         = 34;
  localparam int PW         = 2 * SW;
  localparam int AW         = 36;
  localparam int LATENCY    = ITERS + ITERS + 8;
  localparam logic [SW-1:0] KGAIN = SW'(32'h26DD3B6A);

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  function automatic logic [63:0] step_angle(input int i);
    logic [63:0] e;
    e = 64'(ATAN_TAB[i % 32]) << UPSH;
    if (DNSH > 0) begin
      e = (e + (64'd1 << (DNSH - 1))) >> DNSH;
    end
    return e;
  endfunction
endpackage
`default_nettype wire

@@ src/gcib_sincos.sv @@
// Three-lane rotation CORDIC pipeline giving sine and cosine of three angles.
`default_nettype none
module gcib_sincos (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   v_in,
  input  wire logic [gcib_pkg::ANGLE_BITS-1:0]        ang [3],
  output logic                                        v_out,
  output logic signed [gcib_pkg::SW-1:0]              sin_o [3],
  output logic signed [gcib_pkg::SW-1:0]              cos_o [3]
);
  localparam int ZW = gcib_pkg::ZW;
  localparam int SW = gcib_pkg::SW;
  localparam int N  = gcib_pkg::ITERS;
  localparam logic signed [ZW-1:0] QUARTER = ZW'(64'd1 << (gcib_pkg::ANGLE_BITS - 2));
  localparam logic signed [ZW-1:0] HALF    = ZW'(64'd1 << (gcib_pkg::ANGLE_BITS - 1));

  logic signed [SW-1:0] xs [N+1][3];
  logic signed [SW-1:0] ys [N+1][3];
  logic signed [ZW-1:0] zs [N+1][3];
  logic [2:0]           flip [N+1];
  logic [N:0]           vs;

  always_ff @(posedge clk) begin
    logic signed [ZW-1:0] z;
    for (int l = 0; l < 3; l++) begin
      z = ZW'(signed'(ang[l]));
      xs[0][l] <= gcib_pkg::KGAIN;
      ys[0][l] <= '0;
      if (z > QUARTER) begin
        zs[0][l]   <= z - HALF;
        flip[0][l] <= 1'b1;
      end else if (z < -QUARTER) begin
        zs[0][l]   <= z + HALF;
        flip[0][l] <= 1'b1;
      end else begin
        zs[0][l]   <= z;
        flip[0][l] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs    <= '0;
      v_out <= 1'b0;
    end else begin
      vs    <= {vs[N-1:0], v_in};
      v_out <= vs[N];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic signed [ZW-1:0] STEP = ZW'(gcib_pkg::step_angle(i));
    always_ff @(posedge clk) begin
      flip[i+1] <= flip[i];
      for (int l = 0; l < 3; l++) begin
        if (!zs[i][l][ZW-1]) begin
          xs[i+1][l] <= xs[i][l] - (ys[i][l] >>> i);
          ys[i+1][l] <= ys[i][l] + (xs[i][l] >>> i);
          zs[i+1][l] <= zs[i][l] - STEP;
        end else begin
          xs[i+1][l] <= xs[i][l] + (ys[i][l] >>> i);
          ys[i+1][l] <= ys[i][l] - (xs[i][l] >>> i);
          zs[i+1][l] <= zs[i][l] + STEP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      sin_o[l] <= flip[N][l] ? -ys[N][l] : ys[N][l];
      cos_o[l] <= flip[N][l] ? -xs[N][l] : xs[N][l];
    end
  end
endmodule
`default_nettype wire

@@ src/gcib_atan2.sv @@
// Vectoring CORDIC pipeline giving the binary angle of a vector.
`default_nettype none
module gcib_atan2 (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 v_in,
  input  wire logic                                 degen_in,
  input  wire logic signed [gcib_pkg::AW-1:0]       x_in,
  input  wire logic signed [gcib_pkg::AW-1:0]       y_in,
  output logic                                      v_out,
  output logic                                      degen_out,
  output logic [gcib_pkg::ANGLE_BITS-1:0]           z_out
);
  localparam int AB = gcib_pkg::ANGLE_BITS;
  localparam int AW = gcib_pkg::AW;
  localparam int N  = gcib_pkg::ITERS;
  localparam logic [AB-1:0] HALF = AB'(64'd1 << (AB - 1));

  logic signed [AW-1:0] xs [N+1];
  logic signed [AW-1:0] ys [N+1];
  logic [AB-1:0]        zs [N+1];
  logic [N:0]           dg;
  logic [N:0]           vs;

  always_ff @(posedge clk) begin
    if (x_in[AW-1]) begin
      xs[0] <= -x_in;
      ys[0] <= -y_in;
      zs[0] <= HALF;
    end else begin
      xs[0] <= x_in;
      ys[0] <= y_in;
      zs[0] <= '0;
    end
    dg[0] <= degen_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else begin
      vs <= {vs[N-1:0], v_in};
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic [AB-1:0] STEP = AB'(gcib_pkg::step_angle(i));
    always_ff @(posedge clk) begin
      dg[i+1] <= dg[i];
      if (!ys[i][AW-1]) begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + STEP;
      end else begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - STEP;
      end
    end
  end

  assign v_out     = vs[N];
  assign degen_out = dg[N];
  assign z_out     = zs[N];
endmodule
`default_nettype wire

@@ src/great_circle_initial_bearing.sv @@
// Top level: initial great-circle bearing from two latitude/longitude points.
// An accepted start reaches the done strobe through the input, sine/cosine, product and angle stages.
// Throughput: one word per cycle; busy is always low, results cannot be held off.
// The two 24-stage CORDIC pipelines set the latency.
// Reset clears all valid bits; no done strobe follows until a new word enters.
`default_nettype none
module great_circle_initial_bearing (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] start_lat,
  input  wire logic [31:0] start_lon,
  input  wire logic [31:0] end_lat,
  input  wire logic [31:0] end_lon,
  output logic             done,
  output logic [31:0]      bearing,
  output logic             degenerate
);
  localparam int AB = gcib_pkg::ANGLE_BITS;
  localparam int SW = gcib_pkg::SW;
  localparam int PW = gcib_pkg::PW;
  localparam int AW = gcib_pkg::AW;
  localparam int Q  = gcib_pkg::QSHIFT;

  logic [AB-1:0]        ang [3];
  logic                 v0;
  logic                 vs;
  logic signed [SW-1:0] sn [3];
  logic signed [SW-1:0] cs [3];

  logic                 v1, v2, v3;
  logic signed [PW-1:0] p_y, p_t, p_cs, p_q, p_cs2;
  logic signed [SW-1:0] cd1;
  logic signed [AW-1:0] y2, y3, x3;
  logic signed [SW-1:0] t1;
  logic                 d3;
  logic signed [PW-1:0] diff;

  logic                 va, da;
  logic [AB-1:0]        za;

  function automatic logic [AB-1:0] in_angle(input logic [31:0] v);
    return AB'((64'(v) << gcib_pkg::UPSH) >> gcib_pkg::DNSH);
  endfunction

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    ang[0] <= in_angle(start_lat);
    ang[1] <= in_angle(end_lat);
    ang[2] <= in_angle(end_lon) - in_angle(start_lon);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= start && !busy;
      v1 <= vs;
      v2 <= v1;
      v3 <= v2;
    end
  end

  gcib_sincos u_sincos (
    .clk   (clk),
    .rst   (rst),
    .v_in  (v0),
    .ang   (ang),
    .v_out (vs),
    .sin_o (sn),
    .cos_o (cs)
  );

  always_ff @(posedge clk) begin
    p_y  <= PW'(sn[2]) * PW'(cs[1]);
    p_t  <= PW'(sn[0]) * PW'(cs[1]);
    p_cs <= PW'(cs[0]) * PW'(sn[1]);
    cd1  <= cs[2];
  end

  assign t1 = p_t[Q+SW-1:Q];

  always_ff @(posedge clk) begin
    y2    <= p_y[Q+AW-1:Q];
    p_q   <= PW'(t1) * PW'(cd1);
    p_cs2 <= p_cs;
  end

  assign diff = p_cs2 - p_q;

  always_ff @(posedge clk) begin
    x3 <= diff[Q+AW-1:Q];
    y3 <= y2;
    d3 <= (diff[PW-1:Q] == '0) && (y2 == '0);
  end

  gcib_atan2 u_atan2 (
    .clk       (clk),
    .rst       (rst),
    .v_in      (v3),
    .degen_in  (d3),
    .x_in      (x3),
    .y_in      (y3),
    .v_out     (va),
    .degen_out (da),
    .z_out     (za)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= va;
    end
  end

  always_ff @(posedge clk) begin
    degenerate <= da;
    bearing    <= da ? '0 : 32'((64'(za) >> gcib_pkg::UPSH) << gcib_pkg::DNSH);
  end
endmodule
`default_nettype wire

@@ src/gcib_checker.sv @@
// Port-level checks on the bearing block, bound to the top level.
`default_nettype none
module gcib_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [31:0] bearing,
  input wire logic        degenerate
);
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_word_out: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(gcib_pkg::LATENCY) done)
    else $error("accepted word produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, gcib_pkg::LATENCY))
    else $error("result without an accepted word");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (bearing == 32'd0))
    else $error("degenerate result with nonzero bearing");
endmodule

bind great_circle_initial_bearing gcib_checker u_gcib_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .bearing    (bearing),
  .degenerate (degenerate)
);
`default_nettype wire
